// ----- hw/rtl/mbss_pkg.sv -----
package mbss_pkg;

    // Field widths
    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 48;
    localparam int CNT_W      = 32;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int MASK_W     = 16;
    localparam int LEN_CFG_W  = 5;
    localparam int SIG_BYTES  = 16;
    localparam int SIG_W      = SIG_BYTES * BYTE_W;
    localparam int M_TDATA_W  = ADDR_W + CNT_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIG_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIG_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIG_LEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_BASE = 3'd4;

    // Register reset values
    localparam logic [MASK_W-1:0]    MASK_RESET = '1;
    localparam logic [LEN_CFG_W-1:0] LEN_RESET  = 5'd1;

    // One result transaction
    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] hit_address;
        logic [CNT_W-1:0]  hit_total;
        logic              scan_done;
    } t_result;

endpackage

// ----- hw/rtl/mbss_cell.sv -----
module mbss_cell (
    input  logic                      i_clk,
    input  logic                      i_shift,
    input  logic [mbss_pkg::BYTE_W-1:0] i_byte,
    input  logic [mbss_pkg::BYTE_W-1:0] i_sig,
    input  logic                      i_must,
    output logic [mbss_pkg::BYTE_W-1:0] o_byte,
    output logic                      o_mismatch
);
    import mbss_pkg::*;

    logic [BYTE_W-1:0] r_byte;

    // Compare the byte that lands in this slot on the current shift
    assign o_mismatch = i_must && (i_byte != i_sig);

    // Window slot, handed to the next cell on each accepted byte
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// ----- hw/rtl/mbss_obuf.sv -----
module mbss_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mbss_pkg::t_result i_result,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_pop_ready,
    output mbss_pkg::t_result o_result
);
    import mbss_pkg::*;

    t_result r_head;
    t_result r_skid;
    logic    r_head_valid;
    logic    r_skid_valid;
    logic    w_pop;

    assign w_pop   = r_head_valid && i_pop_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_head_valid;
    assign o_result = r_head;

    // Control: head register plus one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            if (!r_head_valid || w_pop) begin
                r_head_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_head_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (!r_head_valid || w_pop) begin
                r_head <= i_result;
            end else begin
                r_skid <= i_result;
            end
        end else if (w_pop && r_skid_valid) begin
            r_head <= r_skid;
        end
    end

    a_skid_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_head_valid)
        else $error("skid entry held without head entry");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("push into full output buffer");

    a_head_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_pop_ready) |=> (o_valid && $stable(o_result)))
        else $error("waiting result transaction changed");

endmodule

// ----- hw/rtl/masked_byte_signature_scan_core.sv -----
// A result transaction is written into the output buffer when its byte is accepted and offered on m_tvalid from there.
// Throughput: one byte per cycle while s_tready is high; the shift chain of window cells and the masked compare
//   finish each byte in the cycle it is accepted, and a two-entry output buffer absorbs stalls.
// s_tready drops only while the output buffer is full.
// Reset (i_rst_n low, synchronous): counters and buffer cleared, compare_mask all ones,
//   signature_length 1, other configuration registers zero. No clearing pass is needed.
module masked_byte_signature_scan_core #(
    parameter int MAX_SIGNATURE_LEN = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mbss_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mbss_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // Byte stream in
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [mbss_pkg::BYTE_W-1:0]          s_tdata,   // [7:0] data_byte
    input  logic                                 s_tlast,   // end_of_scan
    // Result stream out
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [mbss_pkg::M_TDATA_W-1:0]       m_tdata,   // [47:0] hit_address, [79:48] hit_total
    output logic                                 m_tuser,   // hit
    output logic                                 m_tlast    // scan_done
);
    import mbss_pkg::*;

    localparam int LW = $clog2(MAX_SIGNATURE_LEN + 1);

    // Configuration registers
    logic [CFG_DATA_W-1:0] r_sig_low;
    logic [CFG_DATA_W-1:0] r_sig_high;
    logic [MASK_W-1:0]     r_mask;
    logic [LEN_CFG_W-1:0]  r_sig_len;
    logic [ADDR_W-1:0]     r_scan_base;

    // Scan state
    logic [CNT_W-1:0] r_bytes_seen;
    logic [CNT_W-1:0] r_hit_count;
    logic [CNT_W-1:0] n_bytes_seen;
    logic [CNT_W-1:0] n_hit_count;

    logic                  w_accept;
    logic [LW-1:0]         w_len;
    logic [SIG_W-1:0]      w_sig_all;
    logic [BYTE_W-1:0]     w_slot_sig  [MAX_SIGNATURE_LEN];
    logic                  w_slot_must [MAX_SIGNATURE_LEN];
    logic [BYTE_W-1:0]     w_cell_in   [MAX_SIGNATURE_LEN];
    logic [BYTE_W-1:0]     w_cell_out  [MAX_SIGNATURE_LEN];
    logic [MAX_SIGNATURE_LEN-1:0] w_mismatch;
    logic                  w_hit;
    logic [CNT_W-1:0]      w_offset;
    logic                  w_push;
    logic                  w_buf_ready;
    t_result               w_result;
    t_result               w_out;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = s_tvalid && s_tready;
    assign s_tready    = w_buf_ready;
    assign w_sig_all   = {r_sig_high, r_sig_low};

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sig_low   <= '0;
            r_sig_high  <= '0;
            r_mask      <= MASK_RESET;
            r_sig_len   <= LEN_RESET;
            r_scan_base <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SIG_LOW:   r_sig_low   <= i_cfg_data;
                CFG_SIG_HIGH:  r_sig_high  <= i_cfg_data;
                CFG_MASK:      r_mask      <= i_cfg_data[MASK_W-1:0];
                CFG_SIG_LEN:   r_sig_len   <= i_cfg_data[LEN_CFG_W-1:0];
                CFG_SCAN_BASE: r_scan_base <= i_cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective length: zero reads as one, clamped to the window depth
    always_comb begin
        if (r_sig_len == '0) begin
            w_len = LW'(1);
        end else if ({2'b00, r_sig_len} > 7'(MAX_SIGNATURE_LEN)) begin
            w_len = LW'(MAX_SIGNATURE_LEN);
        end else begin
            w_len = LW'(r_sig_len);
        end
    end

    genvar j;
    generate
        for (j = 0; j < MAX_SIGNATURE_LEN; j++) begin : g_cell
            // Align signature to window slot j (slot 0 is the newest byte):
            // slot j meets signature position len-1-j
            always_comb begin
                w_slot_must[j] = 1'b0;
                w_slot_sig[j]  = '0;
                for (int k = 0; k < SIG_BYTES; k++) begin
                    if ((j + 1 + k <= MAX_SIGNATURE_LEN) && (w_len == LW'(j + 1 + k))) begin
                        w_slot_must[j] = r_mask[k];
                        w_slot_sig[j]  = w_sig_all[BYTE_W*k +: BYTE_W];
                    end
                end
            end

            if (j == 0) begin : g_head
                assign w_cell_in[j] = s_tdata;
            end else begin : g_link
                assign w_cell_in[j] = w_cell_out[j-1];
            end

            mbss_cell u_cell (
                .i_clk      (i_clk),
                .i_shift    (w_accept),
                .i_byte     (w_cell_in[j]),
                .i_sig      (w_slot_sig[j]),
                .i_must     (w_slot_must[j]),
                .o_byte     (w_cell_out[j]),
                .o_mismatch (w_mismatch[j])
            );
        end
    endgenerate

    // Counters, hit decision and start address
    always_comb begin
        n_bytes_seen = (r_bytes_seen == '1) ? r_bytes_seen : r_bytes_seen + 1'b1;
        w_hit        = (n_bytes_seen >= CNT_W'(w_len)) && (w_mismatch == '0);
        w_offset     = n_bytes_seen - CNT_W'(w_len);
        n_hit_count  = r_hit_count;
        if (w_hit && (r_hit_count != '1)) begin
            n_hit_count = r_hit_count + 1'b1;
        end
        w_result.hit         = w_hit;
        w_result.hit_address = w_hit ? (r_scan_base + ADDR_W'(w_offset)) : '0;
        w_result.hit_total   = n_hit_count;
        w_result.scan_done   = s_tlast;
    end

    assign w_push = w_accept && (w_hit || s_tlast);

    // Scan state: cleared after the last byte of a region
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_seen <= '0;
            r_hit_count  <= '0;
        end else if (w_accept) begin
            if (s_tlast) begin
                r_bytes_seen <= '0;
                r_hit_count  <= '0;
            end else begin
                r_bytes_seen <= n_bytes_seen;
                r_hit_count  <= n_hit_count;
            end
        end
    end

    mbss_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_result    (w_result),
        .o_ready     (w_buf_ready),
        .o_valid     (m_tvalid),
        .i_pop_ready (m_tready),
        .o_result    (w_out)
    );

    assign m_tdata = {w_out.hit_total, w_out.hit_address};
    assign m_tuser = w_out.hit;
    assign m_tlast = w_out.scan_done;

    a_result_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("result without hit or end of scan");

    a_no_hit_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[ADDR_W-1:0] == '0))
        else $error("address given without hit");

    a_hit_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[M_TDATA_W-1:ADDR_W] != '0))
        else $error("hit result with zero total");

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_tlast) |=> (r_bytes_seen == '0 && r_hit_count == '0))
        else $error("scan state not cleared after last byte");

endmodule

// ----- dv/masked_byte_signature_scan_core_tb.sv -----
`timescale 1ns / 100ps

module masked_byte_signature_scan_core_tb;
    import mbss_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 80;
    localparam int PHASES         = 12;
    localparam int PHASE_BYTES    = 50;
    localparam int PRESSURE_PHASE = 5;

    // Index that decodes to no register; writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

    // DUT ports
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata     = '0;
    logic                  s_tlast     = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    masked_byte_signature_scan_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Scanner model: register copies and scan state, at reset values
    logic [63:0]          sig_lo    = '0;
    logic [63:0]          sig_hi    = '0;
    logic [MASK_W-1:0]    cmp_mask  = MASK_RESET;
    logic [LEN_CFG_W-1:0] len_cfg   = LEN_RESET;
    logic [ADDR_W-1:0]    base_addr = '0;
    logic [BYTE_W-1:0]    win [SIG_BYTES];   // index 0 holds the newest byte
    logic [CNT_W-1:0]     seen_cnt  = '0;
    logic [CNT_W-1:0]     hit_cnt   = '0;

    t_result scan_reports_q [$];   // reports still owed by the DUT, oldest first
    t_result head_rep;
    int      err_cnt = 0;

    // Idle control shared by the sender and the receiver
    bit no_idle    = 1'b0;
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    bit hold_req   = 1'b0;
    int stall_left = 0;
    int hold_left  = 0;
    int quiet_cycles = 0;

    // Directed stimulus rows
    typedef struct packed {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [63:0]          val;
        logic [BYTE_W-1:0]    b;
        bit                   last;
        bit                   typed;
        t_result              rep;
    } t_stim_row;

    t_stim_row dir_rows [$];

    initial begin
        for (int k = 0; k < SIG_BYTES; k++) win[k] = '0;
    end

    function automatic logic [7:0] sig_at(input int i);
        return (i < 8) ? sig_lo[8*i +: 8] : sig_hi[8*(i-8) +: 8];
    endfunction

    // Length 0 acts as 1, anything past the window is clamped
    function automatic int eff_len();
        if (len_cfg == 0) return 1;
        if (len_cfg > SIG_BYTES) return SIG_BYTES;
        return int'(len_cfg);
    endfunction

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        case (idx)
            CFG_SIG_LOW:   sig_lo    = data;
            CFG_SIG_HIGH:  sig_hi    = data;
            CFG_MASK:      cmp_mask  = data[MASK_W-1:0];
            CFG_SIG_LEN:   len_cfg   = data[LEN_CFG_W-1:0];
            CFG_SCAN_BASE: base_addr = data[ADDR_W-1:0];
            default: ;
        endcase
    endtask

    // Shift one byte into the window and compare; has_rep flags a report
    task automatic window_match_step(input logic [7:0] b, input logic last,
                                     output logic has_rep, output t_result rep);
        int   n;
        logic match;
        n = eff_len();
        for (int k = SIG_BYTES - 1; k > 0; k--) win[k] = win[k-1];
        win[0] = b;
        if (seen_cnt != '1) seen_cnt++;

        match = 1'b0;
        if (seen_cnt >= n) begin
            match = 1'b1;
            for (int k = 0; k < n; k++)
                if (cmp_mask[k] && win[n-1-k] != sig_at(k)) match = 1'b0;
        end

        rep = '0;
        if (match) begin
            rep.hit_address = base_addr + ADDR_W'(seen_cnt) - ADDR_W'(n);
            if (hit_cnt != '1) hit_cnt++;
        end
        rep.hit       = match;
        rep.hit_total = hit_cnt;
        rep.scan_done = last;
        has_rep = match || last;

        // End of region clears the window and the counters
        if (last) begin
            for (int k = 0; k < SIG_BYTES; k++) win[k] = '0;
            seen_cnt = '0;
            hit_cnt  = '0;
        end
    endtask

    // Directed table helpers
    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        t_stim_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        dir_rows.push_back(r);
    endtask

    task automatic add_byte(input logic [7:0] b, input bit last);
        t_stim_row r;
        r = '0;
        r.b    = b;
        r.last = last;
        dir_rows.push_back(r);
    endtask

    task automatic add_byte_rep(input logic [7:0] b, input bit last, input logic hit,
                                input logic [ADDR_W-1:0] addr, input logic [CNT_W-1:0] total);
        t_stim_row r;
        r = '0;
        r.b     = b;
        r.last  = last;
        r.typed = 1'b1;
        r.rep.hit         = hit;
        r.rep.hit_address = addr;
        r.rep.hit_total   = total;
        r.rep.scan_done   = last;
        dir_rows.push_back(r);
    endtask

    // One byte transaction; called and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last,
                             input bit typed, input t_result typed_rep);
        logic    has_rep;
        t_result rep;
        if (tx_idle_en && !no_idle && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge i_clk); while (!s_tready);
        window_match_step(b, last, has_rep, rep);
        if (typed) scan_reports_q.push_back(typed_rep);
        else if (has_rep) scan_reports_q.push_back(rep);
        @(negedge i_clk);
    endtask

    // Stop the byte stream and let every owed report drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (scan_reports_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Receiver: random stall bursts, one long hold on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else if (no_idle || !rx_idle_en) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Report checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (scan_reports_q.size() == 0) begin
                $error("unexpected report: hit %0b addr %h total %0d done %0b",
                       m_tuser, m_tdata[ADDR_W-1:0], m_tdata[ADDR_W +: CNT_W], m_tlast);
                err_cnt++;
            end else begin
                head_rep = scan_reports_q.pop_front();
                if (m_tuser !== head_rep.hit) begin
                    $error("hit: expected %0b, got %0b", head_rep.hit, m_tuser);
                    err_cnt++;
                end
                if (m_tdata[ADDR_W-1:0] !== head_rep.hit_address) begin
                    $error("hit_address: expected %h, got %h",
                           head_rep.hit_address, m_tdata[ADDR_W-1:0]);
                    err_cnt++;
                end
                if (m_tdata[ADDR_W +: CNT_W] !== head_rep.hit_total) begin
                    $error("hit_total: expected %0d, got %0d",
                           head_rep.hit_total, m_tdata[ADDR_W +: CNT_W]);
                    err_cnt++;
                end
                if (m_tlast !== head_rep.scan_done) begin
                    $error("scan_done: expected %0b, got %0b", head_rep.scan_done, m_tlast);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog: too long without any transaction ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main sequence
    initial begin
        t_stim_row         row;
        logic [63:0]       lo_v, hi_v, mask_v, len_v, base_v;
        logic [BYTE_W-1:0] region_q [$];
        int                sent, rlen, n;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset config: length 1, full mask, zero signature
        add_byte_rep(8'h00, 1'b0, 1'b1, 48'h0, 32'd1);
        add_byte    (8'hFF, 1'b0);
        add_byte_rep(8'h00, 1'b1, 1'b1, 48'h2, 32'd2);
        add_byte_rep(8'h5A, 1'b1, 1'b0, 48'h0, 32'd0);   // single-byte region, no hit
        // Length 4, one wildcard, base near the top so the address wraps
        add_cfg(CFG_SIG_LOW,   64'h0123_4567_89AB_3F78);
        add_cfg(CFG_SIG_LEN,   64'd4);
        add_cfg(CFG_MASK,      64'h0000_0000_0000_FFFD);
        add_cfg(CFG_SCAN_BASE, 64'hABCD_FFFF_FFFF_FFFE);
        add_byte(8'h78, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hAB, 1'b0);
        add_byte(8'h89, 1'b0);
        add_byte(8'h78, 1'b0);
        add_byte(8'h3F, 1'b0);
        add_byte(8'hAB, 1'b0);
        add_byte_rep(8'h89, 1'b1, 1'b1, 48'h2, 32'd2);
        // Unused index is ignored; length zero acts as one; empty mask hits every byte
        add_cfg(CFG_IDX_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        add_cfg(CFG_SIG_LEN,    64'hFFFF_FFFF_FFFF_FFE0);
        add_cfg(CFG_MASK,       64'h0);
        add_byte(8'h00, 1'b0);
        add_byte_rep(8'hFF, 1'b1, 1'b1, 48'hFFFF_FFFF_FFFF, 32'd2);
        // Oversized length clamps to the full window; only the end bytes compared
        add_cfg(CFG_SIG_LEN,   64'd31);
        add_cfg(CFG_SIG_HIGH,  64'hFEDC_BA98_7654_3210);
        add_cfg(CFG_MASK,      64'h8001);
        add_cfg(CFG_SCAN_BASE, 64'h1000);
        add_byte(8'h78, 1'b0);
        for (int k = 1; k <= 14; k++) add_byte(8'(k * 18), 1'b0);
        add_byte_rep(8'hFE, 1'b1, 1'b1, 48'h1000, 32'd1);

        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            if (row.is_cfg) begin
                wait_idle();
                write_reg(row.idx, row.val);
            end else begin
                send_byte(row.b, row.last, row.typed, row.rep);
            end
        end

        // Random phases: new settings, then regions seeded with signature copies
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            no_idle    = (p >= PHASES - 2);
            tx_idle_en = ($urandom_range(0, 3) != 0) && (p != PRESSURE_PHASE);
            rx_idle_en = ($urandom_range(0, 3) != 0);

            lo_v = {$urandom, $urandom};
            hi_v = {$urandom, $urandom};
            case ($urandom_range(0, 5))
                0: begin lo_v = '0; hi_v = '0; end
                1: begin lo_v = '1; hi_v = '1; end
                default: ;
            endcase
            case ($urandom_range(0, 5))
                0: mask_v = '1;
                1: mask_v = '0;
                2: mask_v = {$urandom, $urandom};
                default: mask_v = {$urandom, $urandom | $urandom};
            endcase
            if (p == 0) len_v = 64'd16;
            else if (p == 1) len_v = 64'd1;
            else if ($urandom_range(0, 3) == 0) len_v = $urandom_range(0, 31);
            else len_v = $urandom_range(1, 6);
            case ($urandom_range(0, 3))
                0: base_v = '0;
                1: base_v = 64'hFFFF_FFFF_FFFF_FFF0;
                default: base_v = {$urandom, $urandom};
            endcase
            if (p == PRESSURE_PHASE) begin
                mask_v = '0;
                len_v  = 64'd1;
            end

            write_reg(CFG_SIG_LOW,   lo_v);
            write_reg(CFG_SIG_HIGH,  hi_v);
            write_reg(CFG_MASK,      mask_v);
            write_reg(CFG_SIG_LEN,   len_v);
            write_reg(CFG_SCAN_BASE, base_v);

            sent = 0;
            while (sent < PHASE_BYTES) begin
                rlen = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 48);
                n = eff_len();
                while (region_q.size() < rlen) begin
                    if ($urandom_range(0, 7) < 3) begin
                        for (int k = 0; k < n; k++)
                            region_q.push_back(cmp_mask[k] ? sig_at(k) : 8'($urandom));
                    end else if ($urandom_range(0, 1) == 0) begin
                        region_q.push_back(sig_at($urandom_range(0, SIG_BYTES - 1)));
                    end else begin
                        region_q.push_back(8'($urandom));
                    end
                end
                foreach (region_q[k]) begin
                    // Long receiver hold while bytes keep coming
                    if (p == PRESSURE_PHASE && sent == 8) hold_req = 1'b1;
                    send_byte(region_q[k], k == region_q.size() - 1, 1'b0, '0);
                    sent++;
                end
                region_q.delete();
            end
        end

        wait_idle();
        repeat (8) @(negedge i_clk);
        if (scan_reports_q.size() != 0) begin
            $error("%0d reports never arrived", scan_reports_q.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- masked_byte_signature_scan_core.f -----
hw/rtl/mbss_pkg.sv
hw/rtl/mbss_cell.sv
hw/rtl/mbss_obuf.sv
hw/rtl/masked_byte_signature_scan_core.sv
dv/masked_byte_signature_scan_core_tb.sv
